// ===== rtl/eptw_pkg.sv =====
// Shared types, constants and index helpers for the extended page table walker.
`timescale 1ns / 1ps
package eptw_pkg;

	// Walk geometry
	localparam int unsigned TABLE_LEVELS = 4;
	localparam logic [2:0]  LVL_TOP      = 3'(TABLE_LEVELS);

	// Input opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_ENTRY = 1'b1;

	// Result word kinds
	localparam logic [1:0] KIND_REQ = 2'd0;
	localparam logic [1:0] KIND_REC = 2'd1;
	localparam logic [1:0] KIND_SUM = 2'd2;

	// MMIO marker: bits {63,2,1,0} read exactly as write+exec
	localparam logic [3:0] MMIO_MARK = 4'b0110;

	// One item's worth of result words, built in one pass and drained word by word
	typedef struct packed {
		logic        head_valid;
		logic [1:0]  head_kind;
		logic [51:0] head_addr;
		logic [2:0]  head_level;
		logic [8:0]  head_idx;
		logic [63:0] head_value;
		logic [7:0]  head_flags;
		logic        req_valid;
		logic [51:0] req_addr;
		logic [2:0]  req_level;
		logic [8:0]  req_idx;
		logic [2:0]  zero_level;
		logic [47:0] guest;
		logic        sum_valid;
		logic [2:0]  sum_level;
		logic [40:0] sum_frame;
		logic        sum_mapped;
		logic        sum_mmio;
	} eptw_burst_t;

	// Nine-bit table index of a level; level 0 reads as level 1, high levels read zero
	function automatic logic [8:0] level_index(input logic [47:0] ga, input logic [2:0] lvl);
		logic [2:0]  l;
		logic [6:0]  sh;
		logic [63:0] ext;
		logic [63:0] shifted;
		l       = (lvl == 3'd0) ? 3'd1 : lvl;
		sh      = 7'd12 + 7'd9 * ({4'b0, l} - 7'd1);
		ext     = {16'b0, ga};
		shifted = ext >> sh;
		level_index = shifted[8:0];
	endfunction

	// Frame offset inside a large page at the given level
	function automatic logic [35:0] leaf_offset(input logic [35:0] fr, input logic [2:0] lvl);
		logic [6:0]  nb;
		logic [63:0] m;
		if (lvl > 3'd1) begin
			nb = 7'd9 * ({4'b0, lvl} - 7'd1);
			m  = (64'd1 << nb) - 64'd1;
		end else begin
			nb = 7'd0;
			m  = '0;
		end
		leaf_offset = fr & m[35:0];
	endfunction

endpackage

// ===== rtl/eptw_walk_ctrl.sv =====
// Walk state and single-pass decode of one item into a burst of result words.
`timescale 1ns / 1ps
module eptw_walk_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_op,
	input  logic [35:0]          item_frame,
	input  logic [63:0]          item_entry,
	input  logic [63:0]          root,
	output logic                 burst_load,
	output eptw_pkg::eptw_burst_t burst
);
	import eptw_pkg::*;

	logic        busy_q,   busy_n;
	logic [2:0]  level_q,  level_n;
	logic [47:0] guest_q,  guest_n;
	logic [39:0] base_q,   base_n;
	logic        mapped_q, mapped_n;
	logic        mmio_q,   mmio_n;
	logic [2:0]  flvl_q,   flvl_n;
	logic [40:0] fframe_q, fframe_n;

	logic        e_mmio, e_present, e_leaf;
	logic [2:0]  lvl_dn;
	logic [8:0]  idx;

	// Entry decode
	assign e_mmio    = (item_entry != 64'd0) &&
	                   ({item_entry[63], item_entry[2:0]} == MMIO_MARK);
	assign e_present = !e_mmio && (item_entry[2:0] != 3'd0);
	assign e_leaf    = e_present && ((level_q == 3'd1) || item_entry[7]);
	assign lvl_dn    = level_q - 3'd1;

	// Next state and burst for the item in hand
	always_comb begin
		busy_n     = busy_q;
		level_n    = level_q;
		guest_n    = guest_q;
		base_n     = base_q;
		mapped_n   = mapped_q;
		mmio_n     = mmio_q;
		flvl_n     = flvl_q;
		fframe_n   = fframe_q;
		burst      = '0;
		burst_load = 1'b0;
		idx        = '0;
		if (item_valid) begin
			if (item_op == OP_START) begin
				guest_n    = {item_frame, 12'b0};
				mapped_n   = 1'b0;
				mmio_n     = 1'b0;
				flvl_n     = '0;
				fframe_n   = '0;
				burst_load = 1'b1;
				burst.guest = guest_n;
				if (root == 64'd0 || root == '1) begin
					// no table: zero records for every level, then the summary
					busy_n           = 1'b0;
					level_n          = '0;
					base_n           = '0;
					burst.zero_level = LVL_TOP;
					burst.sum_valid  = 1'b1;
				end else begin
					busy_n           = 1'b1;
					level_n          = LVL_TOP;
					base_n           = root[51:12];
					idx              = level_index(guest_n, LVL_TOP);
					burst.head_valid = 1'b1;
					burst.head_kind  = KIND_REQ;
					burst.head_addr  = {root[51:12], idx, 3'b0};
					burst.head_level = LVL_TOP;
					burst.head_idx   = idx;
				end
			end else if (busy_q) begin
				burst_load       = 1'b1;
				burst.guest      = guest_q;
				burst.head_valid = 1'b1;
				burst.head_kind  = KIND_REC;
				burst.head_addr  = {base_q, 12'b0};
				burst.head_level = level_q;
				burst.head_idx   = level_index(guest_q, level_q);
				burst.head_value = item_entry;
				burst.head_flags = {item_entry[9:8], item_entry[2:0], e_leaf, e_present, e_mmio};
				mmio_n = mmio_q | e_mmio;
				if (e_leaf) begin
					mapped_n = 1'b1;
					flvl_n   = level_q;
					fframe_n = 41'(item_entry[51:12]) + 41'(leaf_offset(guest_q[47:12], level_q));
				end
				if (!e_present || e_leaf) begin
					// descent stops here
					busy_n           = 1'b0;
					level_n          = '0;
					base_n           = '0;
					burst.zero_level = lvl_dn;
					burst.sum_valid  = 1'b1;
				end else begin
					base_n          = item_entry[51:12];
					level_n         = lvl_dn;
					idx             = level_index(guest_q, lvl_dn);
					burst.req_valid = 1'b1;
					burst.req_addr  = {item_entry[51:12], idx, 3'b0};
					burst.req_level = lvl_dn;
					burst.req_idx   = idx;
				end
			end
		end
		burst.sum_level  = flvl_n;
		burst.sum_frame  = fframe_n;
		burst.sum_mapped = mapped_n;
		burst.sum_mmio   = mmio_n;
	end

	// Walk state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			level_q  <= '0;
			guest_q  <= '0;
			base_q   <= '0;
			mapped_q <= 1'b0;
			mmio_q   <= 1'b0;
			flvl_q   <= '0;
			fframe_q <= '0;
		end else begin
			busy_q   <= busy_n;
			level_q  <= level_n;
			guest_q  <= guest_n;
			base_q   <= base_n;
			mapped_q <= mapped_n;
			mmio_q   <= mmio_n;
			flvl_q   <= flvl_n;
			fframe_q <= fframe_n;
		end
	end

endmodule

// ===== rtl/eptw_result_seq.sv =====
// Burst register and sequencer: one result word out per unstalled cycle.
`timescale 1ns / 1ps
module eptw_result_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  burst_load,
	input  eptw_pkg::eptw_burst_t burst,
	output logic                  free,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [1:0]            entry_kind,
	output logic [51:0]           address,
	output logic [2:0]            level,
	output logic [8:0]            table_index,
	output logic [63:0]           entry_value,
	output logic [7:0]            entry_flags,
	output logic [40:0]           leaf_frame,
	output logic                  mapped,
	output logic                  mmio_seen,
	output logic                  last
);
	import eptw_pkg::*;

	localparam logic [1:0] PH_HEAD = 2'd0;
	localparam logic [1:0] PH_REQ  = 2'd1;
	localparam logic [1:0] PH_ZERO = 2'd2;
	localparam logic [1:0] PH_SUM  = 2'd3;

	eptw_burst_t burst_q;
	logic        valid_q;
	logic [1:0]  ph_q, ph_n, ph_start;
	logic [2:0]  zl_q;
	logic        done_now, fire;

	assign fire = valid_q && !out_stall;
	assign free = !valid_q || (fire && done_now);

	// Phase after the current word
	always_comb begin
		ph_n     = ph_q;
		done_now = 1'b0;
		unique case (ph_q)
			PH_HEAD: begin
				if (burst_q.req_valid) ph_n = PH_REQ;
				else if (zl_q != 3'd0) ph_n = PH_ZERO;
				else if (burst_q.sum_valid) ph_n = PH_SUM;
				else done_now = 1'b1;
			end
			PH_REQ:  done_now = 1'b1;
			PH_ZERO: begin
				if (zl_q == 3'd1) ph_n = PH_SUM;
			end
			PH_SUM:  done_now = 1'b1;
			default: done_now = 1'b1;
		endcase
	end

	// First phase of a freshly loaded burst
	always_comb begin
		if (burst.head_valid) ph_start = PH_HEAD;
		else if (burst.zero_level != 3'd0) ph_start = PH_ZERO;
		else ph_start = PH_SUM;
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ph_q    <= PH_HEAD;
			zl_q    <= '0;
		end else if (burst_load) begin
			valid_q <= 1'b1;
			ph_q    <= ph_start;
			zl_q    <= burst.zero_level;
		end else if (fire) begin
			if (done_now) valid_q <= 1'b0;
			ph_q <= ph_n;
			if (ph_q == PH_ZERO) zl_q <= zl_q - 3'd1;
		end
	end

	// Burst payload
	always_ff @(posedge clk) begin
		if (burst_load) burst_q <= burst;
	end

	// Output word select
	always_comb begin
		out_valid   = valid_q;
		entry_kind  = KIND_REQ;
		address     = '0;
		level       = '0;
		table_index = '0;
		entry_value = '0;
		entry_flags = '0;
		leaf_frame  = '0;
		mapped      = 1'b0;
		mmio_seen   = 1'b0;
		last        = 1'b0;
		unique case (ph_q)
			PH_HEAD: begin
				entry_kind  = burst_q.head_kind;
				address     = burst_q.head_addr;
				level       = burst_q.head_level;
				table_index = burst_q.head_idx;
				entry_value = burst_q.head_value;
				entry_flags = burst_q.head_flags;
			end
			PH_REQ: begin
				entry_kind  = KIND_REQ;
				address     = burst_q.req_addr;
				level       = burst_q.req_level;
				table_index = burst_q.req_idx;
			end
			PH_ZERO: begin
				entry_kind  = KIND_REC;
				level       = zl_q;
				table_index = level_index(burst_q.guest, zl_q);
			end
			PH_SUM: begin
				entry_kind = KIND_SUM;
				level      = burst_q.sum_level;
				leaf_frame = burst_q.sum_frame;
				mapped     = burst_q.sum_mapped;
				mmio_seen  = burst_q.sum_mmio;
				last       = 1'b1;
			end
			default: entry_kind = KIND_REQ;
		endcase
	end

endmodule

// ===== rtl/ept_table_walker_core.sv =====
// Top level of the four-level extended page table walker.
`timescale 1ns / 1ps
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in       | in        | in_valid / in_stall  | opcode, frame_number, table_entry
//  out      | out       | out_valid / out_stall| entry_kind, address, level, table_index,
//           |           |                      | entry_value, entry_flags, leaf_frame,
//           |           |                      | mapped, mmio_seen, last
//  cfg      | in        | cfg_valid / cfg_ready| cfg_data (root table address)
//
//  An item is registered, decoded against the walk state and turned into 0 to 5 result
//  words (none for an entry with no walk pending), drained from the burst register one
//  word per cycle unless stalled. A start with a root gives 1 word, a table entry that
//  descends gives 2, an ending entry up to 5, a start with no root 5.
//  Items flow at one per cycle while each yields one word; the burst drain sets the rate.
//  Reset clears the walk (idle) and the root register. Output stall holds the word and
//  backs up into the input register, which then raises in_stall. cfg_ready is always high.
module ept_table_walker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [35:0] frame_number,
	input  logic [63:0] table_entry,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  entry_kind,
	output logic [51:0] address,
	output logic [2:0]  level,
	output logic [8:0]  table_index,
	output logic [63:0] entry_value,
	output logic [7:0]  entry_flags,
	output logic [40:0] leaf_frame,
	output logic        mapped,
	output logic        mmio_seen,
	output logic        last
);
	import eptw_pkg::*;

	logic [63:0] root_q;
	logic        valid_s1;
	logic        op_s1;
	logic [35:0] frame_s1;
	logic [63:0] entry_s1;
	logic        seq_free, adv, in_take, burst_load;
	eptw_burst_t burst;

	// Root register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) root_q <= '0;
		else if (cfg_valid && cfg_ready) root_q <= cfg_data;
	end

	// Input register
	assign adv      = valid_s1 && seq_free;
	assign in_stall = valid_s1 && !seq_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_take) valid_s1 <= 1'b1;
		else if (adv) valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1    <= opcode;
			frame_s1 <= frame_number;
			entry_s1 <= table_entry;
		end
	end

	eptw_walk_ctrl u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (adv),
		.item_op    (op_s1),
		.item_frame (frame_s1),
		.item_entry (entry_s1),
		.root       (root_q),
		.burst_load (burst_load),
		.burst      (burst)
	);

	eptw_result_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_load  (burst_load),
		.burst       (burst),
		.free        (seq_free),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.entry_kind  (entry_kind),
		.address     (address),
		.level       (level),
		.table_index (table_index),
		.entry_value (entry_value),
		.entry_flags (entry_flags),
		.leaf_frame  (leaf_frame),
		.mapped      (mapped),
		.mmio_seen   (mmio_seen),
		.last        (last)
	);

	// A new burst only loads when the previous one has drained
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		burst_load |-> (!out_valid || (!out_stall && last) ||
		                (!out_stall && entry_kind == KIND_REQ) ||
		                (!out_stall && entry_kind == KIND_REC)))
		else $error("burst loaded over undrained words");

	// The closing word of a walk is always the summary
	a_last_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (entry_kind == KIND_SUM))
		else $error("last word is not a summary");

	// Read requests always target a real level
	a_req_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && entry_kind == KIND_REQ) |-> (level != 3'd0 && !last))
		else $error("read request with level zero");

	// A mapped summary names its leaf level
	a_map_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last && mapped) |-> (level != 3'd0))
		else $error("mapped summary without leaf level");

endmodule
